@@ hdl/mfr_pkg.sv @@
// Package for the float32 / minifloat repacker.
// Holds the IEEE single constants, register codes and shared struct types.
// No dependencies.
package mfr_pkg;

    localparam int F32_MAN_BITS   = 23;
    localparam int F32_EXP_BITS   = 8;
    localparam int F32_BIAS       = 127;
    localparam int F32_SIGN_SHIFT = 31;
    localparam int WORD_BITS      = 32;
    localparam int NUM_STAGES     = 3;
    localparam int PADDR_BITS     = 3;

    localparam logic [2:0] EXP_WIDTH_RESET = 3'd4;
    localparam logic [4:0] MAN_WIDTH_RESET = 5'd13;
    localparam logic [4:0] MAN_WIDTH_MAX   = 5'd23;

    localparam logic REG_EXP_WIDTH = 1'b0;
    localparam logic REG_MAN_WIDTH = 1'b1;

    localparam logic KIND_ENCODE = 1'b0;
    localparam logic KIND_DECODE = 1'b1;

    typedef struct packed {
        logic [2:0]  exp_raw;
        logic [4:0]  man_raw;
        logic [2:0]  ew;
        logic [4:0]  mw;
        logic [4:0]  shift;
        logic [4:0]  sshift;
        logic [6:0]  half;
        logic [6:0]  exp_mask;
        logic [22:0] man_mask;
    } t_cfg;

    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
        logic [NUM_STAGES-1:0] vld;
    } t_pipe;

endpackage

@@ hdl/mfr_cfg_regs.sv @@
// Configuration registers of the repacker behind an APB-style port.
// Derives the effective widths, shifts and masks used by the datapath.
// Depends on mfr_pkg.
module mfr_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mfr_pkg::PADDR_BITS-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output mfr_pkg::t_cfg                o_cfg
);

    logic [2:0] r_exp_width;
    logic [4:0] r_man_width;
    logic       wr_en;
    logic [2:0] ew;
    logic [4:0] mw;

    assign wr_en = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_width <= mfr_pkg::EXP_WIDTH_RESET;
            r_man_width <= mfr_pkg::MAN_WIDTH_RESET;
        end else if (wr_en) begin
            case (paddr[2])
                mfr_pkg::REG_EXP_WIDTH: r_exp_width <= pwdata[2:0];
                mfr_pkg::REG_MAN_WIDTH: r_man_width <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            mfr_pkg::REG_EXP_WIDTH: prdata = {29'd0, r_exp_width};
            mfr_pkg::REG_MAN_WIDTH: prdata = {27'd0, r_man_width};
            default:                prdata = 32'd0;
        endcase
    end

    always_comb begin
        ew = (r_exp_width == 3'd0) ? 3'd1 : r_exp_width;
        if (r_man_width == 5'd0) begin
            mw = 5'd1;
        end else if (r_man_width > mfr_pkg::MAN_WIDTH_MAX) begin
            mw = mfr_pkg::MAN_WIDTH_MAX;
        end else begin
            mw = r_man_width;
        end
        o_cfg.exp_raw  = r_exp_width;
        o_cfg.man_raw  = r_man_width;
        o_cfg.ew       = ew;
        o_cfg.mw       = mw;
        o_cfg.shift    = mfr_pkg::MAN_WIDTH_MAX - mw;
        o_cfg.sshift   = {2'd0, ew} + mw;
        o_cfg.half     = 7'd1 << (ew - 3'd1);
        o_cfg.exp_mask = 7'((8'd1 << ew) - 8'd1);
        o_cfg.man_mask = 23'((24'd1 << mw) - 24'd1);
    end

endmodule

@@ hdl/mfr_pipe_ctrl.sv @@
// Valid and stage-enable control of the three-stage repacker pipeline.
// A stage loads when it is empty or when the stage after it moves on.
// Depends on mfr_pkg.
module mfr_pipe_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_out_ready,
    output mfr_pkg::t_pipe o_pipe
);

    logic [mfr_pkg::NUM_STAGES-1:0] r_vld;
    logic [mfr_pkg::NUM_STAGES-1:0] n_vld;
    logic [mfr_pkg::NUM_STAGES-1:0] en;

    always_comb begin
        en[mfr_pkg::NUM_STAGES-1] = !r_vld[mfr_pkg::NUM_STAGES-1] || i_out_ready;
        for (int k = mfr_pkg::NUM_STAGES - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
        n_vld = r_vld;
        if (en[0]) begin
            n_vld[0] = i_in_valid;
        end
        for (int k = 1; k < mfr_pkg::NUM_STAGES; k++) begin
            if (en[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_pipe.en  = en;
    assign o_pipe.vld = r_vld;

endmodule

@@ hdl/mfr_datapath.sv @@
// Three register stages of the repacker: round and unpack, clamp and
// extract, then assemble the result word. Depends on mfr_pkg.
module mfr_datapath (
    input  logic           i_clk,
    input  mfr_pkg::t_cfg  i_cfg,
    input  mfr_pkg::t_pipe i_pipe,
    input  logic           i_kind,
    input  logic [31:0]    i_word_in,
    input  logic           i_round_enable,
    output logic [31:0]    o_word_out
);

    logic               r_a_kind;
    logic               r_a_zero;
    logic [31:0]        r_a_word;
    logic [22:0]        r_a_man;
    logic signed [9:0]  r_a_exp;

    logic               r_b_kind;
    logic               r_b_zero;
    logic               r_b_sign;
    logic [7:0]         r_b_exp;
    logic [22:0]        r_b_man;

    logic [31:0]        r_c_word;

    logic [23:0]        a_man24;
    logic [23:0]        a_inc;
    logic               a_carry;
    logic [31:0]        a_packed;
    logic               n_a_zero;
    logic [31:0]        n_a_word;
    logic [22:0]        n_a_man;
    logic signed [9:0]  n_a_exp;

    logic signed [9:0]  b_t;
    logic signed [9:0]  b_mask_s;
    logic [6:0]         b_efield;
    logic [8:0]         b_dexp;
    logic               n_b_zero;
    logic               n_b_sign;
    logic [7:0]         n_b_exp;
    logic [22:0]        n_b_man;

    logic [31:0]        n_c_word;

    always_comb begin
        a_inc = 24'd0;
        if (i_round_enable && (i_cfg.shift != 5'd0)) begin
            a_inc = 24'd1 << (i_cfg.shift - 5'd1);
        end
        a_man24  = {1'b0, i_word_in[22:0]} + a_inc;
        a_carry  = a_man24[23];
        a_packed = i_word_in & ~(32'hFFFF_FFFF << (i_cfg.sshift + 5'd1));
        if (i_kind == mfr_pkg::KIND_DECODE) begin
            n_a_zero = (a_packed == 32'd0);
            n_a_word = a_packed;
        end else begin
            n_a_zero = (i_word_in[30:0] == 31'd0);
            n_a_word = i_word_in;
        end
        n_a_man = a_carry ? 23'd0 : a_man24[22:0];
        n_a_exp = signed'({2'b00, i_word_in[30:23]}) - 10'sd127
                + signed'({9'd0, a_carry});
    end

    always_ff @(posedge i_clk) begin
        if (i_pipe.en[0]) begin
            r_a_kind <= i_kind;
            r_a_zero <= n_a_zero;
            r_a_word <= n_a_word;
            r_a_man  <= n_a_man;
            r_a_exp  <= n_a_exp;
        end
    end

    always_comb begin
        b_t      = r_a_exp + signed'({3'd0, i_cfg.half});
        b_mask_s = signed'({3'd0, i_cfg.exp_mask});
        b_efield = 7'(i_cfg.exp_mask & 7'(r_a_word >> i_cfg.mw));
        b_dexp   = {2'd0, b_efield} + 9'd127 - {2'd0, i_cfg.half};
        if (r_a_kind == mfr_pkg::KIND_DECODE) begin
            n_b_zero = r_a_zero;
            n_b_sign = r_a_word[i_cfg.sshift];
            n_b_exp  = b_dexp[7:0];
            n_b_man  = r_a_word[22:0] & i_cfg.man_mask;
        end else begin
            n_b_zero = r_a_zero || (b_t < -10'sd1);
            n_b_sign = r_a_word[mfr_pkg::F32_SIGN_SHIFT];
            if (b_t < 10'sd0) begin
                n_b_exp = 8'd0;
            end else if (b_t > b_mask_s) begin
                n_b_exp = {1'b0, i_cfg.exp_mask};
            end else begin
                n_b_exp = {1'b0, b_t[6:0]};
            end
            n_b_man = r_a_man >> i_cfg.shift;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pipe.en[1]) begin
            r_b_kind <= r_a_kind;
            r_b_zero <= n_b_zero;
            r_b_sign <= n_b_sign;
            r_b_exp  <= n_b_exp;
            r_b_man  <= n_b_man;
        end
    end

    always_comb begin
        if (r_b_zero) begin
            n_c_word = 32'd0;
        end else if (r_b_kind == mfr_pkg::KIND_DECODE) begin
            n_c_word = {r_b_sign, r_b_exp, 23'(r_b_man << i_cfg.shift)};
        end else begin
            n_c_word = (32'(r_b_sign) << i_cfg.sshift)
                     | (32'(r_b_exp[6:0]) << i_cfg.mw)
                     | {9'd0, r_b_man};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pipe.en[2]) begin
            r_c_word <= n_c_word;
        end
    end

    assign o_word_out = r_c_word;

endmodule

@@ hdl/float32_minifloat_repacker.sv @@
// Top level of the float32 / minifloat repacker.
// Instantiates mfr_cfg_regs, mfr_pipe_ctrl and mfr_datapath; uses mfr_pkg.
//
//   Channel   Direction   Handshake                  Payload
//   in        to block    i_in_valid / o_in_ready    i_kind, i_word_in, i_round_enable
//   out       from block  o_out_valid / i_out_ready  o_word_out
//   config    to block    APB psel/penable/pwrite    paddr, pwdata, prdata
//
// One transfer can enter every cycle while o_in_ready is high; each result passes through the
// three register stages before it is valid on the output and can transfer out.
// A stalled output stage holds its word and stalls only the stages behind it.
// Reset is synchronous and clears the stage valid bits and the configuration registers.
module float32_minifloat_repacker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_kind,
    input  logic [31:0]                    i_word_in,
    input  logic                           i_round_enable,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [31:0]                    o_word_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mfr_pkg::PADDR_BITS-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    mfr_pkg::t_cfg  cfg;
    mfr_pkg::t_pipe pipe;

    assign pready = 1'b1;

    mfr_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (cfg)
    );

    mfr_pipe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .o_pipe      (pipe)
    );

    mfr_datapath u_dp (
        .i_clk          (i_clk),
        .i_cfg          (cfg),
        .i_pipe         (pipe),
        .i_kind         (i_kind),
        .i_word_in      (i_word_in),
        .i_round_enable (i_round_enable),
        .o_word_out     (o_word_out)
    );

    assign o_in_ready  = pipe.en[0];
    assign o_out_valid = pipe.vld[mfr_pkg::NUM_STAGES-1];

`ifndef SYNTH
    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (pipe.vld == '1))
        else $error("input blocked while a stage is empty");

    a_drain_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready) |-> o_in_ready)
        else $error("output transfer did not free the input");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (!o_out_valid && cfg.exp_raw == mfr_pkg::EXP_WIDTH_RESET
                             && cfg.man_raw == mfr_pkg::MAN_WIDTH_RESET))
        else $error("pipeline or registers not cleared by reset");
`endif

endmodule

@@ tb/float32_minifloat_repacker_tb.sv @@
// Self-checking testbench for float32_minifloat_repacker: corner-case and random encode and
// decode transfers under several exponent/mantissa widths, checked against a built-in predictor.
// Depends on mfr_pkg and the RTL under hdl/.
module float32_minifloat_repacker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PA_BITS = mfr_pkg::PADDR_BITS;

    class repack_scoreboard;
        logic [2:0]  exp_bits;
        logic [4:0]  man_bits;
        logic [31:0] expected_words[$];
        int unsigned fault_count;

        function new();
            exp_bits    = mfr_pkg::EXP_WIDTH_RESET;
            man_bits    = mfr_pkg::MAN_WIDTH_RESET;
            fault_count = 0;
        endfunction

        function void flag(string msg);
            fault_count++;
            if (fault_count <= 10) begin
                $display("%0t: %s", $time, msg);
            end
        endfunction

        function void set_reg(logic idx, logic [31:0] value);
            if (idx == mfr_pkg::REG_EXP_WIDTH) begin
                exp_bits = value[2:0];
            end else begin
                man_bits = value[4:0];
            end
        endfunction

        function logic [31:0] reg_value(logic idx);
            return (idx == mfr_pkg::REG_EXP_WIDTH) ? {29'd0, exp_bits} : {27'd0, man_bits};
        endfunction

        function int eff_exp();
            return (exp_bits == 3'd0) ? 1 : int'(exp_bits);
        endfunction

        function int eff_man();
            if (man_bits == 5'd0) begin
                return 1;
            end
            return (man_bits > mfr_pkg::MAN_WIDTH_MAX) ? mfr_pkg::F32_MAN_BITS
                                                       : int'(man_bits);
        endfunction

        function logic [31:0] to_packed(logic [31:0] src, logic rnd);
            int ew, mw, emax, emin, shift, e;
            logic [23:0] frac;
            logic sgn;
            ew    = eff_exp();
            mw    = eff_man();
            emax  = (1 << (ew - 1)) - 1;
            emin  = -emax - 1;
            shift = mfr_pkg::F32_MAN_BITS - mw;
            if (src[30:0] == 31'd0) begin
                return 32'd0;
            end
            frac = {1'b0, src[22:0]};
            e    = int'(src[30:23]) - mfr_pkg::F32_BIAS;
            sgn  = src[mfr_pkg::F32_SIGN_SHIFT];
            if (rnd && shift > 0) begin
                frac = frac + (24'd1 << (shift - 1));
                if (frac[mfr_pkg::F32_MAN_BITS]) begin
                    frac = 24'd0;
                    e++;
                end
            end
            frac = frac >> shift;
            if (e < emin - 1) begin
                return 32'd0;
            end
            if (e < emin) begin
                e = emin;
            end
            if (e > emax) begin
                e = emax;
            end
            return (32'(sgn) << (ew + mw)) | (32'(e - emin) << mw) | 32'(frac);
        endfunction

        function logic [31:0] to_single(logic [31:0] src);
            int ew, mw, emin, e;
            logic [31:0] pk, frac, efield, sgn;
            ew   = eff_exp();
            mw   = eff_man();
            emin = -(1 << (ew - 1));
            pk   = src & ((32'd1 << (ew + mw + 1)) - 32'd1);
            if (pk == 32'd0) begin
                return 32'd0;
            end
            frac   = pk & ((32'd1 << mw) - 32'd1);
            efield = (pk >> mw) & ((32'd1 << ew) - 32'd1);
            sgn    = (pk >> (ew + mw)) & 32'd1;
            e      = int'(efield) + emin + mfr_pkg::F32_BIAS;
            return (sgn << mfr_pkg::F32_SIGN_SHIFT)
                   | ((32'(e) & 32'hff) << mfr_pkg::F32_MAN_BITS)
                   | (frac << (mfr_pkg::F32_MAN_BITS - mw));
        endfunction

        function void note_input(logic kind, logic [31:0] word, logic rnd);
            expected_words.push_back((kind == mfr_pkg::KIND_DECODE) ? to_single(word)
                                                                    : to_packed(word, rnd));
        endfunction

        function void check_word(logic [31:0] actual);
            logic [31:0] want;
            if (expected_words.size() == 0) begin
                flag($sformatf("word_out %08h arrived with no result expected", actual));
                return;
            end
            want = expected_words.pop_front();
            if (actual !== want) begin
                flag($sformatf("word_out mismatch: expected %08h, got %08h", want, actual));
            end
        endfunction
    endclass

    localparam logic [2:0] EXP_PLAN [8] = '{3'd7, 3'd1, 3'd0, 3'd7, 3'd3, 3'd5, 3'd2, 3'd6};
    localparam logic [4:0] MAN_PLAN [8] = '{5'd23, 5'd1, 5'd0, 5'd31, 5'd10, 5'd24, 5'd22, 5'd5};
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 45;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic                  i_kind;
    logic [31:0]           i_word_in;
    logic                  i_round_enable;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [31:0]           o_word_out;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PA_BITS-1:0]    paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    repack_scoreboard chk = new();
    int send_gap_pct = 16;
    int recv_gap_pct = 52;
    int items_sent   = 0;

    float32_minifloat_repacker uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #200us;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_gap_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            chk.check_word(o_word_out);
        end
    end

    task automatic send_item(input logic kind, input logic [31:0] word, input logic rnd);
        logic taken;
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_kind         <= kind;
        i_word_in      <= word;
        i_round_enable <= rnd;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = (o_in_ready === 1'b1);
            if (taken) begin
                chk.note_input(kind, word, rnd);
            end
            @(negedge i_clk);
        end
        items_sent++;
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PA_BITS'({idx, 2'b00});
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        chk.set_reg(idx, value);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata !== chk.reg_value(idx)) begin
            chk.flag($sformatf("register %0d read back %08h, expected %08h",
                               idx, prdata, chk.reg_value(idx)));
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_idle();
        while (chk.expected_words.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    initial begin
        int ew, mw, emin, emax, pick;
        logic        kind;
        logic        rnd;
        logic [31:0] word;
        logic [31:0] mask;
        logic [2:0]  exp_cfg;
        logic [4:0]  man_cfg;

        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_kind         = mfr_pkg::KIND_ENCODE;
        i_word_in      = 32'd0;
        i_round_enable = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = 32'd0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset widths: 4 exponent bits, 13 mantissa bits.
        send_item(mfr_pkg::KIND_ENCODE, 32'h0000_0000, 1'b0);
        send_item(mfr_pkg::KIND_ENCODE, 32'h8000_0000, 1'b1);
        send_item(mfr_pkg::KIND_ENCODE, 32'h0000_0001, 1'b0);
        send_item(mfr_pkg::KIND_ENCODE, 32'h807f_ffff, 1'b1);
        send_item(mfr_pkg::KIND_ENCODE, 32'h7f80_0000, 1'b0);
        send_item(mfr_pkg::KIND_ENCODE, 32'hffff_ffff, 1'b1);
        send_item(mfr_pkg::KIND_ENCODE, 32'h3f80_0000, 1'b0);
        send_item(mfr_pkg::KIND_ENCODE, 32'h3f80_0200, 1'b1);
        send_item(mfr_pkg::KIND_ENCODE, 32'h3f80_01ff, 1'b1);
        send_item(mfr_pkg::KIND_ENCODE, 32'h3fff_ffff, 1'b1);
        send_item(mfr_pkg::KIND_ENCODE, 32'h3b00_0000, 1'b0);
        send_item(mfr_pkg::KIND_ENCODE, 32'h3a80_0000, 1'b0);
        send_item(mfr_pkg::KIND_ENCODE, 32'h3a7f_ffff, 1'b1);
        send_item(mfr_pkg::KIND_ENCODE, 32'hbaff_ffff, 1'b1);
        send_item(mfr_pkg::KIND_ENCODE, 32'h4300_0000, 1'b0);
        send_item(mfr_pkg::KIND_ENCODE, 32'h437f_ffff, 1'b1);
        send_item(mfr_pkg::KIND_ENCODE, 32'h7f7f_ffff, 1'b0);
        send_item(mfr_pkg::KIND_DECODE, 32'h0000_0000, 1'b0);
        send_item(mfr_pkg::KIND_DECODE, 32'h0002_0000, 1'b0);
        send_item(mfr_pkg::KIND_DECODE, 32'hfffc_0000, 1'b1);
        send_item(mfr_pkg::KIND_DECODE, 32'hffff_ffff, 1'b1);
        send_item(mfr_pkg::KIND_DECODE, 32'h0003_ffff, 1'b0);
        send_item(mfr_pkg::KIND_DECODE, 32'h0000_0001, 1'b1);

        for (int phase = 0; phase < PHASES; phase++) begin
            i_in_valid <= 1'b0;
            wait_idle();
            exp_cfg = (phase < 8) ? EXP_PLAN[phase] : 3'($urandom_range(7));
            man_cfg = (phase < 8) ? MAN_PLAN[phase] : 5'($urandom_range(31));
            write_reg(mfr_pkg::REG_EXP_WIDTH, ($urandom & ~32'h7) | 32'(exp_cfg));
            write_reg(mfr_pkg::REG_MAN_WIDTH, ($urandom & ~32'h1f) | 32'(man_cfg));
            ew   = chk.eff_exp();
            mw   = chk.eff_man();
            emax = (1 << (ew - 1)) - 1;
            emin = -emax - 1;
            mask = (32'd1 << (ew + mw + 1)) - 32'd1;

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (items_sent < 160) begin
                    send_gap_pct = 16;
                    recv_gap_pct = 52;
                end else if (items_sent < 320) begin
                    send_gap_pct = 52;
                    recv_gap_pct = 16;
                end else begin
                    send_gap_pct = 0;
                    recv_gap_pct = 0;
                end
                kind = $urandom_range(1) ? mfr_pkg::KIND_DECODE : mfr_pkg::KIND_ENCODE;
                rnd  = 1'($urandom_range(1));
                pick = $urandom_range(99);
                word = $urandom;
                if (kind == mfr_pkg::KIND_ENCODE) begin
                    if (pick < 60) begin
                        word[30:23] = 8'(mfr_pkg::F32_BIAS + emin - 3
                                         + $urandom_range(emax - emin + 6));
                        if (pick < 15) begin
                            word[22:0] = 23'h7f_ffff - 23'($urandom_range(3));
                        end
                    end else if (pick >= 80) begin
                        case ($urandom_range(3))
                            0: begin
                                word = word & 32'h8000_0000;
                            end
                            1: begin
                                word = word & 32'h807f_ffff;
                            end
                            2: begin
                                word = word | 32'h7f80_0000;
                            end
                            default: begin
                                word[30:23] = 8'(mfr_pkg::F32_BIAS + emin - 2
                                                 + $urandom_range(1));
                            end
                        endcase
                    end
                end else begin
                    if (pick < 50) begin
                        word = word & mask;
                    end else if (pick >= 95) begin
                        word = (word & ~mask) | (32'd1 << (ew + mw));
                    end else if (pick >= 90) begin
                        word = word & ~mask;
                    end
                end
                send_item(kind, word, rnd);
            end
        end

        i_in_valid <= 1'b0;
        wait_idle();
        repeat (mfr_pkg::NUM_STAGES + 8) @(negedge i_clk);
        if (chk.fault_count == 0 && chk.expected_words.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
hdl/mfr_pkg.sv
hdl/mfr_cfg_regs.sv
hdl/mfr_pipe_ctrl.sv
hdl/mfr_datapath.sv
hdl/float32_minifloat_repacker.sv
tb/float32_minifloat_repacker_tb.sv
